>>> hdl/eti_pkg.sv
// Shared types and constants for the escape-time iteration block.
`timescale 1ns / 1ps

package eti_pkg;

    // Width of every configuration register and of the APB data bus.
    localparam int REG_BITS = 32;
    // Five registers at byte addresses 0 to 16.
    localparam int APB_ADDR_BITS = 5;

    localparam logic signed [REG_BITS-1:0] ORIGIN_RE_RESET = -32'sd536870912;
    localparam logic signed [REG_BITS-1:0] ORIGIN_IM_RESET = -32'sd301989888;
    localparam logic signed [REG_BITS-1:0] STEP_RE_RESET   = 32'sd201327;
    localparam logic signed [REG_BITS-1:0] STEP_IM_RESET   = 32'sd201327;
    localparam int                         MAX_ITER_RESET  = 40;

    typedef enum logic [2:0] {
        REG_ORIGIN_RE = 3'd0,
        REG_ORIGIN_IM = 3'd1,
        REG_STEP_RE   = 3'd2,
        REG_STEP_IM   = 3'd3,
        REG_MAX_ITER  = 3'd4
    } reg_idx_t;

    // Geometry of the image window, handed from the register file to the front end.
    typedef struct packed {
        logic signed [REG_BITS-1:0] origin_re;
        logic signed [REG_BITS-1:0] origin_im;
        logic signed [REG_BITS-1:0] step_re;
        logic signed [REG_BITS-1:0] step_im;
    } cfg_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_MUL,
        CS_ADD,
        CS_DONE
    } core_state_t;

endpackage

>>> hdl/eti_pix_if.sv
// Pixel coordinate channel with valid/ready handshake.
`timescale 1ns / 1ps

interface eti_pix_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> hdl/eti_res_if.sv
// Escape-time result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface eti_res_if #(
    parameter int COORD_BITS = 12,
    parameter int ITER_BITS  = 11
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [ITER_BITS-1:0]  iteration_count;
    logic                  in_set;

    modport source (output valid, output out_x, output out_y, output iteration_count,
                    output in_set, input ready);
    modport sink   (input valid, input out_x, input out_y, input iteration_count,
                    input in_set, output ready);
endinterface

>>> hdl/eti_cfg.sv
// APB register file holding the image window and the iteration limit.
`timescale 1ns / 1ps

module eti_cfg #(
    parameter int ITER_BITS = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eti_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [eti_pkg::REG_BITS-1:0]       pwdata,
    output logic [eti_pkg::REG_BITS-1:0]       prdata,
    output logic                               pready,
    output eti_pkg::cfg_t                      cfg,
    output logic [ITER_BITS-1:0]               max_iter
);

    eti_pkg::cfg_t        cfg_reg;
    logic [ITER_BITS-1:0] max_iter_reg;
    logic [2:0]           idx;
    logic                 wr_en;

    assign idx    = paddr[eti_pkg::APB_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re <= eti_pkg::ORIGIN_RE_RESET;
            cfg_reg.origin_im <= eti_pkg::ORIGIN_IM_RESET;
            cfg_reg.step_re   <= eti_pkg::STEP_RE_RESET;
            cfg_reg.step_im   <= eti_pkg::STEP_IM_RESET;
            max_iter_reg      <= ITER_BITS'(eti_pkg::MAX_ITER_RESET);
        end
        else if (wr_en)
        begin
            unique case (idx)
                eti_pkg::REG_ORIGIN_RE: cfg_reg.origin_re <= $signed(pwdata);
                eti_pkg::REG_ORIGIN_IM: cfg_reg.origin_im <= $signed(pwdata);
                eti_pkg::REG_STEP_RE:   cfg_reg.step_re   <= $signed(pwdata);
                eti_pkg::REG_STEP_IM:   cfg_reg.step_im   <= $signed(pwdata);
                eti_pkg::REG_MAX_ITER:  max_iter_reg      <= pwdata[ITER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            eti_pkg::REG_ORIGIN_RE: prdata = cfg_reg.origin_re;
            eti_pkg::REG_ORIGIN_IM: prdata = cfg_reg.origin_im;
            eti_pkg::REG_STEP_RE:   prdata = cfg_reg.step_re;
            eti_pkg::REG_STEP_IM:   prdata = cfg_reg.step_im;
            eti_pkg::REG_MAX_ITER:
                prdata = {{(eti_pkg::REG_BITS-ITER_BITS){1'b0}}, max_iter_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg      = cfg_reg;
    assign max_iter = max_iter_reg;

endmodule

>>> hdl/eti_front.sv
// Front end: takes pixel transfers and maps each pixel onto its point c.
`timescale 1ns / 1ps

module eti_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  eti_pkg::cfg_t         cfg,
    eti_pix_if.sink               pix,
    output logic                  push,
    input  logic                  push_ready,
    output logic [2*COORD_BITS+2*(eti_pkg::REG_BITS+COORD_BITS+1)-1:0] push_data
);

    localparam int CW = eti_pkg::REG_BITS + COORD_BITS + 1;

    logic                  fr_valid_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic signed [CW-1:0]  cr_reg;
    logic signed [CW-1:0]  ci_reg;
    logic signed [CW-1:0]  prod_re;
    logic signed [CW-1:0]  prod_im;
    logic signed [CW-1:0]  cr_next;
    logic signed [CW-1:0]  ci_next;
    logic                  accept;

    assign pix.ready = !fr_valid_reg || push_ready;
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        prod_re = $signed({1'b0, pix.pixel_x}) * cfg.step_re;
        prod_im = $signed({1'b0, pix.pixel_y}) * cfg.step_im;
        cr_next = prod_re + {{(CW-eti_pkg::REG_BITS){cfg.origin_re[eti_pkg::REG_BITS-1]}},
                             cfg.origin_re};
        ci_next = prod_im + {{(CW-eti_pkg::REG_BITS){cfg.origin_im[eti_pkg::REG_BITS-1]}},
                             cfg.origin_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (pix.ready)
        begin
            fr_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= pix.pixel_x;
            y_reg  <= pix.pixel_y;
            cr_reg <= cr_next;
            ci_reg <= ci_next;
        end
    end

    assign push      = fr_valid_reg;
    assign push_data = {x_reg, y_reg, cr_reg, ci_reg};

endmodule

>>> hdl/eti_fifo.sv
// Two-entry queue between the front end and the iteration core.
`timescale 1ns / 1ps

module eti_fifo #(
    parameter int WIDTH = 114
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/eti_core.sv
// Back end: iterates z = z*z + c for one point and registers the result.
`timescale 1ns / 1ps

module eti_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ITER_BITS-1:0]  max_iter,
    input  logic                  q_valid,
    input  logic [2*COORD_BITS+2*(eti_pkg::REG_BITS+COORD_BITS+1)-1:0] q_data,
    output logic                  q_pop,
    eti_res_if.source             res
);

    localparam int CW  = eti_pkg::REG_BITS + COORD_BITS + 1;
    // Largest magnitude of z that can still pass the escape test is 2^(F+1).
    localparam int MW  = FRAC_BITS + 2;
    localparam int ZW  = ((FRAC_BITS + 3) > CW ? (FRAC_BITS + 3) : CW) + 1;
    localparam int PW  = 2 * MW;
    localparam int XW  = ((PW + 1) > ZW ? (PW + 1) : ZW);
    localparam logic [ZW-1:0] MAG_LIM = ZW'(1) << (MW - 1);
    localparam logic [PW:0]   ESC_LIM = (PW+1)'(1) << (2 * FRAC_BITS + 2);

    eti_pkg::core_state_t state_reg;
    eti_pkg::core_state_t state_next;

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic signed [CW-1:0]  cr_reg;
    logic signed [CW-1:0]  ci_reg;
    logic [ZW-1:0]         zr_reg;
    logic [ZW-1:0]         zi_reg;
    logic [ITER_BITS-1:0]  iter_reg;
    logic [PW-1:0]         rr_reg;
    logic [PW-1:0]         ii_reg;
    logic [PW-1:0]         ri_reg;
    logic                  neg_reg;
    logic                  big_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [ITER_BITS-1:0]  out_cnt_reg;
    logic                  out_set_reg;

    logic                  load;
    logic                  do_mul;
    logic                  do_upd;
    logic                  finish;
    logic                  slot_free;
    logic                  at_limit;
    logic                  escape;

    logic [ZW-1:0]         abs_r;
    logic [ZW-1:0]         abs_i;
    logic [MW-1:0]         mag_r;
    logic [MW-1:0]         mag_i;
    logic [PW:0]           mag_sum;
    logic signed [XW-1:0]  diff_x;
    logic signed [XW-1:0]  ri_mag;
    logic signed [XW-1:0]  ri_x;
    logic signed [XW-1:0]  diff_sh;
    logic signed [XW-1:0]  ri_sh;
    logic [ZW-1:0]         zr_new;
    logic [ZW-1:0]         zi_new;

    assign at_limit  = (iter_reg == max_iter);
    assign slot_free = !out_valid_reg || res.ready;

    // Multiply side: magnitudes above 2^(F+1) escape whatever the other part is,
    // so only the low MW bits of each magnitude go to the multipliers.
    always_comb
    begin
        abs_r = zr_reg[ZW-1] ? (ZW'(0) - zr_reg) : zr_reg;
        abs_i = zi_reg[ZW-1] ? (ZW'(0) - zi_reg) : zi_reg;
        mag_r = abs_r[MW-1:0];
        mag_i = abs_i[MW-1:0];
    end

    // Update side: exact escape test, then the floored shifts back to F fraction bits.
    always_comb
    begin
        mag_sum = {1'b0, rr_reg} + {1'b0, ii_reg};
        escape  = big_reg || (mag_sum > ESC_LIM);
        diff_x  = $signed({{(XW-PW){1'b0}}, rr_reg}) - $signed({{(XW-PW){1'b0}}, ii_reg});
        ri_mag  = $signed({{(XW-PW){1'b0}}, ri_reg});
        ri_x    = neg_reg ? -ri_mag : ri_mag;
        diff_sh = diff_x >>> FRAC_BITS;
        ri_sh   = ri_x >>> (FRAC_BITS - 1);
        zr_new  = diff_sh[ZW-1:0] + {{(ZW-CW){cr_reg[CW-1]}}, cr_reg};
        zi_new  = ri_sh[ZW-1:0] + {{(ZW-CW){ci_reg[CW-1]}}, ci_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        do_mul     = 1'b0;
        do_upd     = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            eti_pkg::CS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    load       = 1'b1;
                    state_next = eti_pkg::CS_MUL;
                end
            end
            eti_pkg::CS_MUL:
            begin
                if (at_limit)
                begin
                    state_next = eti_pkg::CS_DONE;
                end
                else
                begin
                    do_mul     = 1'b1;
                    state_next = eti_pkg::CS_ADD;
                end
            end
            eti_pkg::CS_ADD:
            begin
                if (escape)
                begin
                    state_next = eti_pkg::CS_DONE;
                end
                else
                begin
                    do_upd     = 1'b1;
                    state_next = eti_pkg::CS_MUL;
                end
            end
            eti_pkg::CS_DONE:
            begin
                if (slot_free)
                begin
                    finish     = 1'b1;
                    state_next = eti_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = eti_pkg::CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eti_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            {x_reg, y_reg, cr_reg, ci_reg} <= q_data;
            zr_reg   <= '0;
            zi_reg   <= '0;
            iter_reg <= '0;
        end
        else if (do_upd)
        begin
            zr_reg   <= zr_new;
            zi_reg   <= zi_new;
            iter_reg <= iter_reg + ITER_BITS'(1);
        end
        if (do_mul)
        begin
            rr_reg  <= mag_r * mag_r;
            ii_reg  <= mag_i * mag_i;
            ri_reg  <= mag_r * mag_i;
            neg_reg <= zr_reg[ZW-1] ^ zi_reg[ZW-1];
            big_reg <= (abs_r > MAG_LIM) || (abs_i > MAG_LIM);
        end
        if (finish)
        begin
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            out_cnt_reg <= iter_reg;
            out_set_reg <= at_limit;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.out_x           = out_x_reg;
    assign res.out_y           = out_y_reg;
    assign res.iteration_count = out_cnt_reg;
    assign res.in_set          = out_set_reg;

endmodule

>>> hdl/escape_time_iteration.sv
// Escape-time unit: each iteration runs a multiply step, then a test and update step.
// The core loads a point, iterates until it reaches the limit or escapes, then waits in a done
// state for a free output slot. Sustained rate is one pixel per core pass; the front-end
// register and the two-entry queue hold pixels ahead of the core.
// rst_n is asynchronous: it empties the front end, queue, core and output register
// and loads the reset window and limit; no clearing pass is needed.
`timescale 1ns / 1ps

module escape_time_iteration #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    eti_pix_if.sink                           pix,
    eti_res_if.source                         res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eti_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [eti_pkg::REG_BITS-1:0]      pwdata,
    output logic [eti_pkg::REG_BITS-1:0]      prdata,
    output logic                              pready
);

    localparam int QW = 2 * COORD_BITS + 2 * (eti_pkg::REG_BITS + COORD_BITS + 1);

    eti_pkg::cfg_t        cfg;
    logic [ITER_BITS-1:0] max_iter;
    logic                 push;
    logic                 push_ready;
    logic [QW-1:0]        push_data;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_data;

    eti_cfg #(
        .ITER_BITS (ITER_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .max_iter (max_iter)
    );

    eti_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix        (pix),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    eti_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    eti_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_iter (max_iter),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .res      (res)
    );

endmodule

>>> hdl/eti_chk.sv
// Port-level checker for the escape-time unit, bound to the top level.
`timescale 1ns / 1ps

module eti_chk #(
    parameter int ITER_BITS = 11
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              pix_valid,
    input logic                              pix_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [ITER_BITS-1:0]              res_count,
    input logic                              res_in_set,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [eti_pkg::APB_ADDR_BITS-1:0] paddr,
    input logic [eti_pkg::REG_BITS-1:0]      pwdata
);

    logic [ITER_BITS-1:0] limit_reg;
    logic [3:0]           pending_reg;
    logic                 in_xfer;
    logic                 out_xfer;

    assign in_xfer  = pix_valid && pix_ready;
    assign out_xfer = res_valid && res_ready;

    // Shadow of the iteration limit as written over APB.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ITER_BITS'(eti_pkg::MAX_ITER_RESET);
        end
        else if (psel && penable && pwrite &&
                 paddr[eti_pkg::APB_ADDR_BITS-1:2] == eti_pkg::REG_MAX_ITER)
        begin
            limit_reg <= pwdata[ITER_BITS-1:0];
        end
    end

    // Pixels taken in whose results have not yet been transferred out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 4'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 4'd0)
        else $error("result offered with no pixel outstanding");

    a_in_set_matches_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_in_set == (res_count == limit_reg)) && (res_count <= limit_reg))
        else $error("count and in-set flag disagree with the iteration limit");

    a_res_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before its transfer");

    a_res_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_count) && $stable(res_in_set))
        else $error("result changed while stalled");

endmodule

bind escape_time_iteration eti_chk #(
    .ITER_BITS (ITER_BITS)
) u_eti_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix.valid),
    .pix_ready  (pix.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_count  (res.iteration_count),
    .res_in_set (res.in_set),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata)
);

>>> tb/tb_top.sv
// Self-checking testbench for the escape-time iteration block: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;
    import eti_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 28;
    localparam int ITER_BITS     = 11;
    localparam int NUM_REGS      = 5;
    localparam int LAST_REG_SLOT = (1 << APB_ADDR_BITS) / 4 - 1;
    localparam int GAP_PERCENT   = 16;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 50;
    localparam int STEADY_PHASE  = 3;
    localparam int PAUSE_PHASE   = 5;
    localparam int LONG_PHASE    = 7;
    localparam int LONG_ITEMS    = 4;
    localparam int LONG_LIMIT    = 2000;
    localparam int TOP_LIMIT     = (1 << ITER_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ITER_BITS-1:0]  count;
        logic                  in_set;
    } escape_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [REG_BITS-1:0]      pwdata = '0;
    logic [REG_BITS-1:0]      prdata;
    logic                     pready;

    eti_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
    eti_res_if #(.COORD_BITS(COORD_BITS), .ITER_BITS(ITER_BITS)) res_ch ();

    escape_time_iteration #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .ITER_BITS (ITER_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix_ch),
        .res    (res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #5 clk = ~clk;

    // Window and limit as the block should currently hold them.
    logic signed [REG_BITS-1:0] win_origin_re = ORIGIN_RE_RESET;
    logic signed [REG_BITS-1:0] win_origin_im = ORIGIN_IM_RESET;
    logic signed [REG_BITS-1:0] win_step_re   = STEP_RE_RESET;
    logic signed [REG_BITS-1:0] win_step_im   = STEP_IM_RESET;
    logic [ITER_BITS-1:0]       iter_limit    = ITER_BITS'(MAX_ITER_RESET);

    pixel_t  pixel_q[$];
    escape_t escape_q[$];
    pixel_t  drive_px;
    escape_t mon_want;
    logic    gapless = 1'b0;
    int      n_queued = 0;
    int      n_accepted = 0;
    int      n_checked = 0;
    int      n_in_set = 0;
    int      n_settings = 0;
    int      n_errors = 0;

    function automatic bit take_gap();
        return !gapless && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    // Escape time of one pixel under the current window, with exact wide products.
    function automatic escape_t predict_escape(logic [COORD_BITS-1:0] px,
                                               logic [COORD_BITS-1:0] py);
        logic signed [63:0]  cr, ci, zr, zi;
        logic signed [127:0] rr, ii, ri;
        logic [127:0]        bound;
        int unsigned         n;
        escape_t             r;
        cr = win_origin_re + $signed({{(64-COORD_BITS){1'b0}}, px}) * win_step_re;
        ci = win_origin_im + $signed({{(64-COORD_BITS){1'b0}}, py}) * win_step_im;
        zr = '0;
        zi = '0;
        n = 0;
        bound = 128'd1 << (2 * FRAC_BITS + 2);
        while (n < iter_limit) begin
            rr = zr * zr;
            ii = zi * zi;
            if ($unsigned(rr + ii) > bound)
                break;
            ri = zr * zi;
            // Arithmetic shifts round towards minus infinity; the top bits simply wrap.
            zr = ((rr - ii) >>> FRAC_BITS) + cr;
            zi = (ri >>> (FRAC_BITS - 1)) + ci;
            n++;
        end
        r.x = px;
        r.y = py;
        r.count = n[ITER_BITS-1:0];
        r.in_set = (n == iter_limit);
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    task automatic write_reg(input int idx, input logic [REG_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        // The register takes the value at this edge.
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_RE: win_origin_re = value;
            REG_ORIGIN_IM: win_origin_im = value;
            REG_STEP_RE:   win_step_re = value;
            REG_STEP_IM:   win_step_im = value;
            REG_MAX_ITER:  iter_limit = value[ITER_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [REG_BITS-1:0] o_re, input logic [REG_BITS-1:0] o_im,
                              input logic [REG_BITS-1:0] s_re, input logic [REG_BITS-1:0] s_im);
        write_reg(REG_ORIGIN_RE, o_re);
        write_reg(REG_ORIGIN_IM, o_im);
        write_reg(REG_STEP_RE, s_re);
        write_reg(REG_STEP_IM, s_im);
        n_settings++;
    endtask

    task automatic queue_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        pixel_q.push_back('{x: x, y: y});
        n_queued++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || escape_q.size() != 0);
    endtask

    // Pixel driver: a new pixel is offered once the previous transfer has happened.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pix_ch.valid   <= 1'b0;
            pix_ch.pixel_x <= '0;
            pix_ch.pixel_y <= '0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (pixel_q.size() != 0 && !take_gap()) begin
                drive_px = pixel_q.pop_front();
                pix_ch.valid   <= 1'b1;
                pix_ch.pixel_x <= drive_px.x;
                pix_ch.pixel_y <= drive_px.y;
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !take_gap();
    end

    // Monitor: predicts on each pixel transfer and checks each result transfer in order.
    always @(posedge clk) begin
        if (rst_n && pix_ch.valid && pix_ch.ready) begin
            escape_q.push_back(predict_escape(pix_ch.pixel_x, pix_ch.pixel_y));
            n_accepted++;
        end
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (escape_q.size() == 0) begin
                $error("result transfer with no pixel outstanding");
                n_errors++;
            end else begin
                mon_want = escape_q.pop_front();
                check_field("out_x", mon_want.x, res_ch.out_x);
                check_field("out_y", mon_want.y, res_ch.out_y);
                check_field("iteration_count", mon_want.count, res_ch.iteration_count);
                check_field("in_set", mon_want.in_set, res_ch.in_set);
                n_checked++;
                if (mon_want.in_set)
                    n_in_set++;
            end
        end
    end

    initial begin
        logic [REG_BITS-1:0] o_re, o_im, s_re, s_im;
        int unsigned         lim;
        int                  items;
        rst_n          = 1'b0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        res_ch.ready   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        n_settings++;

        // Reset window: corners, alternating bits, the origin of the plane and the left tip.
        queue_pixel('0, '0);
        queue_pixel('1, '1);
        queue_pixel('1, '0);
        queue_pixel('0, '1);
        queue_pixel(12'd2667, 12'd1500);
        queue_pixel(12'd0, 12'd1500);
        queue_pixel(12'd2000, 12'd1500);
        queue_pixel(12'hAAA, 12'h555);
        queue_pixel(12'h555, 12'hAAA);
        wait_drained();

        // Writes to unmapped slots must leave the window alone.
        for (int i = NUM_REGS; i <= LAST_REG_SLOT; i++)
            write_reg(i, $urandom);
        queue_pixel(12'd2667, 12'd1500);
        wait_drained();

        // A zero limit runs no iteration and still reports the point as inside.
        write_reg(REG_MAX_ITER, '0);
        queue_pixel(12'd2667, 12'd1500);
        queue_pixel('0, '0);
        wait_drained();

        write_reg(REG_MAX_ITER, TOP_LIMIT);
        queue_pixel(12'd2667, 12'd1500);
        queue_pixel(12'd2000, 12'd1500);
        wait_drained();

        write_reg(REG_MAX_ITER, 32'd1);
        queue_pixel(12'd2667, 12'd1500);
        queue_pixel('1, '1);
        wait_drained();

        // Huge points escape straight after the first iteration; a zero window keeps c at zero up to the limit.
        write_reg(REG_MAX_ITER, LONG_LIMIT);
        set_window(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_pixel('0, '0);
        queue_pixel('1, '1);
        wait_drained();
        set_window(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_pixel('0, '0);
        queue_pixel('1, '1);
        wait_drained();
        set_window('0, '0, '0, '0);
        queue_pixel('1, '1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if ($urandom_range(5) == 0) begin
                // Arbitrary window: mostly points far outside the set.
                o_re = $urandom;
                o_im = $urandom;
                s_re = $urandom;
                s_im = $urandom;
            end else begin
                // Window of about two to four units placed over the set.
                o_re = -32'($urandom_range(671088640, 402653184));
                o_im = -32'($urandom_range(402653184, 268435456));
                s_re = $urandom_range(260000, 120000);
                s_im = $urandom_range(260000, 120000);
                if ($urandom_range(3) == 0) begin
                    o_re = $urandom_range(268435456, 134217728);
                    s_re = -s_re;
                end
            end
            case ($urandom_range(4))
                0:       lim = $urandom_range(3);
                1:       lim = MAX_ITER_RESET;
                default: lim = $urandom_range(64, 4);
            endcase
            items = PHASE_ITEMS;
            if (ph == LONG_PHASE) begin
                lim = LONG_LIMIT;
                items = LONG_ITEMS;
            end
            gapless <= (ph == STEADY_PHASE);
            set_window(o_re, o_im, s_re, s_im);
            write_reg(REG_MAX_ITER, lim);
            for (int i = 0; i < items; i++) begin
                // Hold the sender back mid-phase until every result is home.
                if (ph == PAUSE_PHASE && i == items / 2)
                    wait_drained();
                queue_pixel($urandom, $urandom);
            end
            wait_drained();
        end

        repeat (2 * iter_limit + 10) @(posedge clk);
        $display("%0d pixels checked under %0d window settings, limits from zero to %0d;",
                 n_checked, n_settings, TOP_LIMIT);
        $display("%0d of them reached their limit, the rest escaped.", n_in_set);
        if (n_errors == 0 && escape_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #6ms;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/eti_pkg.sv
hdl/eti_pix_if.sv
hdl/eti_res_if.sv
hdl/eti_cfg.sv
hdl/eti_front.sv
hdl/eti_fifo.sv
hdl/eti_core.sv
hdl/escape_time_iteration.sv
hdl/eti_chk.sv
tb/tb_top.sv
